FILE: hdl/rrgf_pkg.sv
// Shared types, codes, sine table and arithmetic helpers for the rectangle grid fill unit.
`default_nettype none
package rrgf_pkg;

  localparam int ANGLE_STEPS = 360;
  localparam int QUARTER     = ANGLE_STEPS / 4;
  localparam int Q_FRAC      = 14;
  localparam int CW          = 14;  // width of signed cell coordinates

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PAINT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] REG_CELLS_PER_HALF_M = 3'd0;
  localparam logic [2:0] REG_OFFSET_CELLS     = 3'd1;
  localparam logic [2:0] REG_HALF_WIDTH       = 3'd2;
  localparam logic [2:0] REG_HALF_LENGTH      = 3'd3;
  localparam logic [2:0] REG_ROW_LENGTH       = 3'd4;
  localparam logic [2:0] REG_COLUMN_HEIGHT    = 3'd5;

  localparam logic [14:0] QSINE [QUARTER+1] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997, 15'd2280,
    15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240, 15'd4516,
    15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402, 15'd6664,
    15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438, 15'd8682,
    15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531,
    15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
    15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330,
    15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191,
    15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826,
    15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225,
    15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_addr;
    logic rd_mem;
    logic p_trig;
    logic p_ext;
    logic p_box;
    logic c_mul;
    logic c_test;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cell_last;
  } sts_t;

  // Q1.14 sine of an angle below two full turns.
  function automatic logic signed [15:0] sin_q14(input logic [9:0] deg);
    logic [9:0] d;
    logic [6:0] r;
    logic       neg;
    logic signed [15:0] v;
    d = (deg >= 10'(ANGLE_STEPS)) ? deg - 10'(ANGLE_STEPS) : deg;
    if (d < 10'(QUARTER)) begin
      r = d[6:0];
      neg = 1'b0;
    end else if (d < 10'(2 * QUARTER)) begin
      r = 7'(10'(2 * QUARTER) - d);
      neg = 1'b0;
    end else if (d < 10'(3 * QUARTER)) begin
      r = 7'(d - 10'(2 * QUARTER));
      neg = 1'b1;
    end else begin
      r = 7'(10'(ANGLE_STEPS) - d);
      neg = 1'b1;
    end
    v = signed'({1'b0, QSINE[r]});
    return neg ? -v : v;
  endfunction

  // Divide by 2^14 with truncation toward zero.
  function automatic logic signed [CW-1:0] trunc_q14(input logic signed [29:0] n);
    logic signed [29:0] t;
    t = (n < 0) ? n + 30'sd16383 : n;
    return CW'(t >>> Q_FRAC);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rotated_rectangle_grid_fill_unit.sv
// Top level of the rotated rectangle grid fill unit: configuration registers and wiring.
//
// Channel  | Ports                                              | Handshake
// command  | start, busy, operation_i .. cell_y_i               | taken when start & !busy
// result   | result_valid_o, read_value_o, cells_written_o      | one-cycle strobe
// config   | cfg_we_i, cfg_index_i, cfg_wdata_i                 | written when cfg_we_i
//
// A read word forms its address, then reads the grid memory; a clear word sweeps every grid entry.
// A paint word runs the trig, extent and box steps, then the multiply and test steps of the
// single cell walker for each cell of its bounding box.
// After reset the grid memory is swept to zero, one entry a cycle, across all
// MAX_GRID_WIDTH*MAX_GRID_HEIGHT entries with busy high; configuration writes are taken.
// Results cannot be stalled; one word is in work at a time.
`default_nettype none
module rotated_rectangle_grid_fill_unit #(
  parameter int MAX_GRID_WIDTH  = 512,
  parameter int MAX_GRID_HEIGHT = 256
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire        [1:0]  operation_i,
  input  wire signed [4:0]  center_x_half_m_i,
  input  wire        [4:0]  center_y_half_m_i,
  input  wire        [8:0]  angle_deg_i,
  input  wire        [6:0]  paint_value_i,
  input  wire        [8:0]  cell_x_i,
  input  wire        [7:0]  cell_y_i,
  output logic              result_valid_o,
  output logic       [6:0]  read_value_o,
  output logic       [11:0] cells_written_o,
  input  wire               cfg_we_i,
  input  wire        [2:0]  cfg_index_i,
  input  wire        [9:0]  cfg_wdata_i
);

  logic [6:0]        k_q;
  logic signed [9:0] off_q;
  logic [5:0]        hw_q, hl_q;
  logic [9:0]        row_q;
  logic [8:0]        col_q;

  rrgf_pkg::cmd_t cmd;
  rrgf_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 7'd10;
      off_q <= '0;
      hw_q <= 6'd7;
      hl_q <= 6'd7;
      row_q <= 10'd280;
      col_q <= 9'd160;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rrgf_pkg::REG_CELLS_PER_HALF_M: k_q <= cfg_wdata_i[6:0];
        rrgf_pkg::REG_OFFSET_CELLS:     off_q <= signed'(cfg_wdata_i);
        rrgf_pkg::REG_HALF_WIDTH:       hw_q <= cfg_wdata_i[5:0];
        rrgf_pkg::REG_HALF_LENGTH:      hl_q <= cfg_wdata_i[5:0];
        rrgf_pkg::REG_ROW_LENGTH:       row_q <= cfg_wdata_i;
        rrgf_pkg::REG_COLUMN_HEIGHT:    col_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  rrgf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (operation_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  rrgf_dpath #(
    .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (operation_i),
    .cxh_i           (center_x_half_m_i),
    .cyh_i           (center_y_half_m_i),
    .deg_i           (angle_deg_i),
    .val_i           (paint_value_i),
    .cx_i            (cell_x_i),
    .cy_i            (cell_y_i),
    .cfg_k_i         (k_q),
    .cfg_off_i       (off_q),
    .cfg_hw_i        (hw_q),
    .cfg_hl_i        (hl_q),
    .cfg_row_i       (row_q),
    .cfg_col_i       (col_q),
    .read_value_o    (read_value_o),
    .cells_written_o (cells_written_o)
  );

endmodule
`default_nettype wire

FILE: hdl/rrgf_ctrl.sv
// Sequencer for clear, paint and read items of the rectangle grid fill unit.
`default_nettype none
module rrgf_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [1:0]        op_i,
  input  rrgf_pkg::sts_t   sts_i,
  output rrgf_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_ADDR, S_RD_MEM, S_P_TRIG, S_P_EXT, S_P_BOX,
    S_C_MUL, S_C_TEST, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   item_clr_q, item_clr_d;
  logic   busy_q, done_q;

  always_comb begin
    state_d = state_q;
    item_clr_d = item_clr_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (op_i)
            rrgf_pkg::OP_CLEAR: begin
              state_d = S_CLEAR;
              item_clr_d = 1'b1;
            end
            rrgf_pkg::OP_PAINT: state_d = S_P_TRIG;
            rrgf_pkg::OP_READ:  state_d = S_RD_ADDR;
            default:            state_d = S_RESULT;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = item_clr_q ? S_RESULT : S_IDLE;
          item_clr_d = 1'b0;
        end
      end
      S_RD_ADDR: begin
        cmd_o.rd_addr = 1'b1;
        state_d = S_RD_MEM;
      end
      S_RD_MEM: begin
        cmd_o.rd_mem = 1'b1;
        state_d = S_RESULT;
      end
      S_P_TRIG: begin
        cmd_o.p_trig = 1'b1;
        state_d = S_P_EXT;
      end
      S_P_EXT: begin
        cmd_o.p_ext = 1'b1;
        state_d = S_P_BOX;
      end
      S_P_BOX: begin
        cmd_o.p_box = 1'b1;
        state_d = S_C_MUL;
      end
      S_C_MUL: begin
        cmd_o.c_mul = 1'b1;
        state_d = S_C_TEST;
      end
      S_C_TEST: begin
        cmd_o.c_test = 1'b1;
        state_d = sts_i.cell_last ? S_RESULT : S_C_MUL;
      end
      S_RESULT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      item_clr_q <= 1'b0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      item_clr_q <= item_clr_d;
      busy_q <= (state_d != S_IDLE);
      done_q <= (state_d == S_RESULT);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_step, cmd_o.c_test, cmd_o.rd_mem}))
    else $error("grid memory port used twice in one cycle");

endmodule
`default_nettype wire

FILE: hdl/rrgf_dpath.sv
// Datapath: geometry arithmetic, cell walker and the occupancy grid memory.
`default_nettype none
module rrgf_dpath #(
  parameter int MAX_GRID_WIDTH  = 512,
  parameter int MAX_GRID_HEIGHT = 256
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  rrgf_pkg::cmd_t           cmd_i,
  output rrgf_pkg::sts_t           sts_o,
  input  wire        [1:0]         op_i,
  input  wire signed [4:0]         cxh_i,
  input  wire        [4:0]         cyh_i,
  input  wire        [8:0]         deg_i,
  input  wire        [6:0]         val_i,
  input  wire        [8:0]         cx_i,
  input  wire        [7:0]         cy_i,
  input  wire        [6:0]         cfg_k_i,
  input  wire signed [9:0]         cfg_off_i,
  input  wire        [5:0]         cfg_hw_i,
  input  wire        [5:0]         cfg_hl_i,
  input  wire        [9:0]         cfg_row_i,
  input  wire        [8:0]         cfg_col_i,
  output logic       [6:0]         read_value_o,
  output logic       [11:0]        cells_written_o
);

  localparam int CW    = rrgf_pkg::CW;
  localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_GRID_WIDTH + 1);
  localparam int HW    = $clog2(MAX_GRID_HEIGHT + 1);
  localparam int WL    = (WW > 10) ? WW : 10;
  localparam int HL    = (HW > 9) ? HW : 9;

  logic [6:0] mem [DEPTH];

  logic [1:0]  op_q;
  logic signed [4:0] cxh_q;
  logic [4:0]  cyh_q;
  logic [8:0]  deg_q;
  logic [6:0]  val_q;
  logic [8:0]  cx_q;
  logic [7:0]  cy_q;

  logic signed [15:0] s_q, c_q;
  logic signed [CW-1:0] gx_q, gy_q;
  logic [20:0] hwc_q, hls_q, hws_q, hlc_q;
  logic signed [CW-1:0] bx0_q, bx1_q, by0_q, by1_q, x_q, y_q;
  logic signed [30:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic        inb_q, rd_ok_q;
  logic [AW-1:0] addr_q, clr_q;
  logic [6:0]  rdata_q;
  logic [11:0] count_q;

  logic [WL-1:0] row_ext;
  logic [HL-1:0] col_ext;
  logic [WW-1:0] wact;
  logic [HW-1:0] hact;
  logic signed [12:0] gx_prod;
  logic [14:0] abs_s, abs_c;
  logic [21:0] ex, ey;
  logic signed [29:0] gxs, gys;
  logic signed [CW:0] dx, dy;
  logic signed [31:0] rx, ry;
  logic [31:0] arx, ary;
  logic        hit, x_in, y_in;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [6:0]  mem_wdata;

  always_comb begin
    row_ext = WL'(cfg_row_i);
    col_ext = HL'(cfg_col_i);
    wact = (row_ext > WL'(MAX_GRID_WIDTH)) ? WW'(MAX_GRID_WIDTH) : WW'(row_ext);
    hact = (col_ext > HL'(MAX_GRID_HEIGHT)) ? HW'(MAX_GRID_HEIGHT) : HW'(col_ext);
    gx_prod = cxh_q * $signed({1'b0, cfg_k_i});
    abs_s = s_q[15] ? 15'(-s_q) : 15'(s_q);
    abs_c = c_q[15] ? 15'(-c_q) : 15'(c_q);
    ex = 22'(hwc_q) + 22'(hls_q);
    ey = 22'(hws_q) + 22'(hlc_q);
    gxs = 30'(gx_q) <<< rrgf_pkg::Q_FRAC;
    gys = 30'(gy_q) <<< rrgf_pkg::Q_FRAC;
    dx = (CW+1)'(x_q) - (CW+1)'(gx_q);
    dy = (CW+1)'(y_q) - (CW+1)'(gy_q);
    x_in = !x_q[CW-1] && (16'(unsigned'(x_q)) < 16'(wact));
    y_in = !y_q[CW-1] && (16'(unsigned'(y_q)) < 16'(hact));
    rx = 32'(pxc_q) + 32'(pys_q);
    ry = 32'(pyc_q) - 32'(pxs_q);
    arx = rx[31] ? 32'(-rx) : 32'(rx);
    ary = ry[31] ? 32'(-ry) : 32'(ry);
    hit = inb_q && (arx <= 32'({cfg_hw_i, 14'b0})) && (ary <= 32'({cfg_hl_i, 14'b0}));
    sts_o.clr_last = (clr_q == AW'(DEPTH - 1));
    sts_o.cell_last = (x_q == bx1_q) && (y_q == by1_q);
    mem_we = cmd_i.clr_step || (cmd_i.c_test && hit);
    mem_waddr = cmd_i.clr_step ? clr_q : addr_q;
    mem_wdata = cmd_i.clr_step ? 7'd0 : val_q;
    read_value_o = (op_q == rrgf_pkg::OP_READ && rd_ok_q) ? rdata_q : 7'd0;
    cells_written_o = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      count_q <= '0;
      op_q <= rrgf_pkg::OP_CLEAR;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= sts_o.clr_last ? '0 : clr_q + AW'(1);
      end
      if (cmd_i.load) begin
        count_q <= '0;
        op_q <= op_i;
      end else if (cmd_i.c_test && hit && count_q != 12'hfff) begin
        count_q <= count_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cxh_q <= cxh_i;
      cyh_q <= cyh_i;
      deg_q <= deg_i;
      val_q <= val_i;
      cx_q <= cx_i;
      cy_q <= cy_i;
    end
    if (cmd_i.rd_addr) begin
      rd_ok_q <= (16'(cx_q) < 16'(wact)) && (16'(cy_q) < 16'(hact));
      addr_q <= AW'(AW'(cy_q) * AW'(wact)) + AW'(cx_q);
    end
    if (cmd_i.p_trig) begin
      s_q <= rrgf_pkg::sin_q14(10'(deg_q));
      c_q <= rrgf_pkg::sin_q14(10'(deg_q) + 10'(rrgf_pkg::QUARTER));
      gx_q <= CW'(gx_prod) + CW'(cfg_off_i);
      gy_q <= signed'(CW'(cyh_q) * CW'(cfg_k_i));
    end
    if (cmd_i.p_ext) begin
      hwc_q <= cfg_hw_i * abs_c;
      hls_q <= cfg_hl_i * abs_s;
      hws_q <= cfg_hw_i * abs_s;
      hlc_q <= cfg_hl_i * abs_c;
    end
    if (cmd_i.p_box) begin
      bx0_q <= rrgf_pkg::trunc_q14(gxs - signed'(30'(ex)));
      bx1_q <= rrgf_pkg::trunc_q14(gxs + signed'(30'(ex)));
      by0_q <= rrgf_pkg::trunc_q14(gys - signed'(30'(ey)));
      by1_q <= rrgf_pkg::trunc_q14(gys + signed'(30'(ey)));
      x_q <= rrgf_pkg::trunc_q14(gxs - signed'(30'(ex)));
      y_q <= rrgf_pkg::trunc_q14(gys - signed'(30'(ey)));
    end
    if (cmd_i.c_mul) begin
      pxc_q <= dx * c_q;
      pys_q <= dy * s_q;
      pyc_q <= dy * c_q;
      pxs_q <= dx * s_q;
      inb_q <= x_in && y_in;
      addr_q <= AW'(AW'(y_q) * AW'(wact)) + AW'(x_q);
    end
    if (cmd_i.c_test) begin
      // Walk the box column by column, each column bottom to top.
      if (y_q == by1_q) begin
        y_q <= by0_q;
        x_q <= x_q + CW'(1);
      end else begin
        y_q <= y_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_mem) begin
      rdata_q <= mem[addr_q];
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/rotated_rectangle_grid_fill_unit_tb.sv
// Self-checking testbench for the rotated rectangle grid fill unit with its own grid predictor.
`default_nettype none
module rotated_rectangle_grid_fill_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W      = 512;
  localparam int GRID_H      = 256;
  localparam int GRID_DEPTH  = GRID_W * GRID_H;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int IDLE_PCT    = 34;

  // The fourth operation code does nothing and returns zeros.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [6:0]  read_value;
    logic [11:0] cells_written;
  } cell_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  operation_i;
  logic signed [4:0] center_x_half_m_i;
  logic [4:0]  center_y_half_m_i;
  logic [8:0]  angle_deg_i;
  logic [6:0]  paint_value_i;
  logic [8:0]  cell_x_i;
  logic [7:0]  cell_y_i;
  logic        result_valid_o;
  logic [6:0]  read_value_o;
  logic [11:0] cells_written_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [9:0]  cfg_wdata_i;

  rotated_rectangle_grid_fill_unit dut (.*);

  // Predictor state: grid contents and register copies.
  logic [6:0]        grid_mem [GRID_DEPTH];
  logic [6:0]        scale_q;
  logic signed [9:0] offset_q;
  logic [5:0]        half_w_q;
  logic [5:0]        half_l_q;
  logic [9:0]        row_len_q;
  logic [8:0]        col_h_q;

  cell_result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  n_paint = 0, n_read = 0, n_clear = 0, n_cfg = 0, n_checked = 0;
  bit           idle_on = 1'b1;
  int           last_gx = 0, last_gy = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: read %0d written %0d", read_value_o,
                   cells_written_o);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (read_value_o !== want.read_value || cells_written_o !== want.cells_written) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on word %0d: read exp %0d got %0d, written exp %0d got %0d",
                     n_checked, want.read_value, read_value_o, want.cells_written,
                     cells_written_o);
        end
      end
    end
  end

  function automatic int sine_q14(int unsigned deg);
    int unsigned d, quad, r;
    int v;
    d = deg % rrgf_pkg::ANGLE_STEPS;
    quad = d / 90;
    r = d % 90;
    v = (quad & 1) ? int'(rrgf_pkg::QSINE[90 - r]) : int'(rrgf_pkg::QSINE[r]);
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int unsigned width_now();
    return row_len_q > GRID_W ? GRID_W : row_len_q;
  endfunction

  function automatic int unsigned height_now();
    return col_h_q > GRID_H ? GRID_H : col_h_q;
  endfunction

  function automatic int unsigned paint_rectangle(logic signed [4:0] cxh, logic [4:0] cyh,
                                                  logic [8:0] deg, logic [6:0] value);
    longint s, c, gx, gy, ex, ey, bx0, bx1, by0, by1, dx, dy, rx, ry, hw, hl, w, h;
    int unsigned count;
    count = 0;
    hw = half_w_q;
    hl = half_l_q;
    w = width_now();
    h = height_now();
    gx = longint'(cxh) * longint'(scale_q) + longint'(offset_q);
    gy = longint'(cyh) * longint'(scale_q);
    s = sine_q14(deg);
    c = sine_q14(deg + 90);
    ex = mag(hw * c) + mag(hl * s);
    ey = mag(hw * s) + mag(hl * c);
    bx0 = (gx * 16384 - ex) / 16384;
    bx1 = (gx * 16384 + ex) / 16384;
    by0 = (gy * 16384 - ey) / 16384;
    by1 = (gy * 16384 + ey) / 16384;
    for (longint x = bx0; x <= bx1; x++) begin
      if (x < 0 || x >= w) continue;
      for (longint y = by0; y <= by1; y++) begin
        if (y < 0 || y >= h) continue;
        dx = x - gx;
        dy = y - gy;
        rx = dx * c + dy * s;
        ry = dy * c - dx * s;
        if (mag(rx) <= hw * 16384 && mag(ry) <= hl * 16384) begin
          grid_mem[y * w + x] = value;
          if (count < 4095) count++;
        end
      end
    end
    last_gx = int'(gx);
    last_gy = int'(gy);
    return count;
  endfunction

  task automatic send_word(logic [1:0] op, logic signed [4:0] cxh, logic [4:0] cyh,
                           logic [8:0] deg, logic [6:0] pv, logic [8:0] x, logic [7:0] y);
    cell_result_t r;
    int unsigned gaps;
    start <= 1'b1;
    operation_i <= op;
    center_x_half_m_i <= cxh;
    center_y_half_m_i <= cyh;
    angle_deg_i <= deg;
    paint_value_i <= pv;
    cell_x_i <= x;
    cell_y_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r.read_value = '0;
    r.cells_written = '0;
    case (op)
      rrgf_pkg::OP_CLEAR: begin
        foreach (grid_mem[i]) grid_mem[i] = '0;
        n_clear++;
      end
      rrgf_pkg::OP_PAINT: begin
        r.cells_written = 12'(paint_rectangle(cxh, cyh, deg, pv));
        n_paint++;
      end
      rrgf_pkg::OP_READ: begin
        if (x < width_now() && y < height_now()) r.read_value = grid_mem[y * width_now() + x];
        n_read++;
      end
      default: ;
    endcase
    pending_results.push_back(r);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      gaps = $urandom_range(1, 4);
      repeat (gaps) @(posedge clk_i);
    end
  endtask

  // Drains every outstanding word so the block is idle before a register write.
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [9:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rrgf_pkg::REG_CELLS_PER_HALF_M: scale_q = data[6:0];
      rrgf_pkg::REG_OFFSET_CELLS:     offset_q = signed'(data);
      rrgf_pkg::REG_HALF_WIDTH:       half_w_q = data[5:0];
      rrgf_pkg::REG_HALF_LENGTH:      half_l_q = data[5:0];
      rrgf_pkg::REG_ROW_LENGTH:       row_len_q = data;
      rrgf_pkg::REG_COLUMN_HEIGHT:    col_h_q = data[8:0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic set_all(int sc, int off, int hw, int hl, int rl, int ch);
    settle();
    cfg_write(rrgf_pkg::REG_CELLS_PER_HALF_M, 10'(sc));
    cfg_write(rrgf_pkg::REG_OFFSET_CELLS, 10'(off));
    cfg_write(rrgf_pkg::REG_HALF_WIDTH, 10'(hw));
    cfg_write(rrgf_pkg::REG_HALF_LENGTH, 10'(hl));
    cfg_write(rrgf_pkg::REG_ROW_LENGTH, 10'(rl));
    cfg_write(rrgf_pkg::REG_COLUMN_HEIGHT, 10'(ch));
  endtask

  task automatic test_reset_defaults();
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    send_word(rrgf_pkg::OP_PAINT, 5, 5, 0, 100, 0, 0);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 50, 50);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 400, 200);
    send_word(OP_UNUSED, -16, 31, 511, 127, 511, 255);
  endtask

  task automatic test_angles();
    send_word(rrgf_pkg::OP_PAINT, 10, 8, 45, 127, 0, 0);
    send_word(rrgf_pkg::OP_PAINT, 20, 8, 90, 1, 0, 0);
    send_word(rrgf_pkg::OP_PAINT, -16, 3, 359, 64, 0, 0);
    send_word(rrgf_pkg::OP_PAINT, 15, 31, 400, 33, 0, 0);
    send_word(rrgf_pkg::OP_PAINT, 3, 12, 511, 99, 0, 0);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 100, 80);
  endtask

  task automatic test_register_extremes();
    set_all(127, 511, 63, 0, 280, 160);
    send_word(rrgf_pkg::OP_PAINT, -4, 1, 30, 77, 0, 0);
    set_all(0, -512, 0, 63, 280, 160);
    send_word(rrgf_pkg::OP_PAINT, 0, 0, 0, 55, 0, 0);
    set_all(1, 100, 63, 63, 1023, 511);
    send_word(rrgf_pkg::OP_PAINT, 0, 0, 45, 12, 0, 0);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 100, 0);
    set_all(10, 0, 7, 7, 0, 0);
    send_word(rrgf_pkg::OP_PAINT, 5, 5, 0, 9, 0, 0);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_stride_and_clear();
    set_all(10, 0, 7, 7, 280, 160);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 50, 50);
    settle();
    cfg_write(rrgf_pkg::REG_ROW_LENGTH, 10'd300);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 30, 47);
    send_word(rrgf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_word(rrgf_pkg::OP_READ, 0, 0, 0, 0, 30, 47);
  endtask

  task automatic test_random_traffic();
    int unsigned pick, sz;
    int rx, ry;
    for (int phase = 0; phase < 6; phase++) begin
      sz = (phase == 4) ? 20 : 8;
      idle_on = (phase != 2);
      set_all($urandom_range(1, 20), int'($urandom_range(0, 300)) - 60,
              $urandom_range(0, sz), $urandom_range(0, sz),
              (phase == 3) ? $urandom_range(513, 1023) : $urandom_range(1, 512),
              (phase == 5) ? $urandom_range(257, 511) : $urandom_range(1, 256));
      if (phase == 1 || phase == 4) send_word(rrgf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
      for (int n = 0; n < 250; n++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_word(rrgf_pkg::OP_PAINT, 5'($urandom), 5'($urandom), 9'($urandom),
                    7'($urandom), 9'($urandom), 8'($urandom));
        end else if (pick < 80) begin
          // Reads aim near the centre of the last painted rectangle.
          rx = last_gx + int'($urandom_range(0, 24)) - 12;
          ry = last_gy + int'($urandom_range(0, 24)) - 12;
          send_word(rrgf_pkg::OP_READ, 5'($urandom), 5'($urandom), 9'($urandom),
                    7'($urandom), 9'(rx), 8'(ry));
        end else if (pick < 96) begin
          send_word(rrgf_pkg::OP_READ, 5'($urandom), 5'($urandom), 9'($urandom),
                    7'($urandom), 9'($urandom), 8'($urandom));
        end else begin
          send_word(OP_UNUSED, 5'($urandom), 5'($urandom), 9'($urandom), 7'($urandom),
                    9'($urandom), 8'($urandom));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = rrgf_pkg::OP_READ;
    center_x_half_m_i = '0;
    center_y_half_m_i = '0;
    angle_deg_i = '0;
    paint_value_i = '0;
    cell_x_i = '0;
    cell_y_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = rrgf_pkg::REG_CELLS_PER_HALF_M;
    cfg_wdata_i = '0;
    foreach (grid_mem[i]) grid_mem[i] = '0;
    scale_q = 7'd10;
    offset_q = '0;
    half_w_q = 6'd7;
    half_l_q = 6'd7;
    row_len_q = 10'd280;
    col_h_q = 9'd160;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_angles();
    test_register_extremes();
    test_stride_and_clear();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d paints, %0d reads, %0d clears and %0d register writes;",
             n_paint, n_read, n_clear, n_cfg);
    $display("%0d result words checked, %0d mismatches.", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
